[rtl/page_frame_bitmap_allocator_defines.svh]
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pfba_pkg.sv]
`timescale 1ns / 1ps

package pfba_pkg;

	localparam int MAX_PAGES_DEF = 512;

	localparam logic [9:0] TOTAL_RST    = 10'd512;
	localparam logic [9:0] RESERVED_RST = 10'd0;
	localparam logic [9:0] COUNT_MAX    = 10'd1023;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_BADPAGE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		REG_TOTAL    = 1'b0,
		REG_RESERVED = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_FREE_CHK,
		S_RESP
	} state_t;

endpackage

[rtl/page_frame_bitmap_allocator.sv]
`timescale 1ns / 1ps
// Init writes all WORDS bitmap words, WORDS = ceil(MAX_PAGES / 32) (16 at the default size).
// Allocate scans the words below the page limit, one bitmap word read per cycle.
// Free reads the word, checks and writes it back, then responds; one item in flight at a time.
// The bitmap memory has one read and one write port, with registered read.
// Reset clears control state, then a clearing pass over all WORDS words zeroes the bitmap;
// no item is accepted during it, configuration writes are taken as ever.

`include "page_frame_bitmap_allocator_defines.svh"

module page_frame_bitmap_allocator #(
	parameter int MAX_PAGES = pfba_pkg::MAX_PAGES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [9:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] op,
	input  logic [8:0] page,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [8:0] alloc_page,
	output logic [1:0] status,
	output logic [9:0] free_count
);

	localparam int WORDS = (MAX_PAGES + 31) / 32;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = $clog2(WORDS + 1);
	localparam int BW    = (CW + 5 > 11) ? CW + 5 : 11;

	// Pages at or above base that lie below bound, as a word mask.
	function automatic logic [31:0] low_mask(input logic [BW-1:0] base,
		input logic [BW-1:0] bound);
		logic [BW-1:0] top;
		logic [31:0]   m;
		top = base + BW'(32);
		if (bound >= top) begin
			m = '1;
		end else if (bound <= base) begin
			m = '0;
		end else begin
			m = (32'd1 << bound[4:0]) - 32'd1;
		end
		return m;
	endfunction

	pfba_pkg::state_t  state_q, state_d;
	logic [9:0]        total_q, reserved_q;
	logic [9:0]        free_q, free_d;
	logic [CW-1:0]     scan_w_q, scan_w_d;
	logic [AW-1:0]     ev_w_q, ev_w_d;
	logic              rv_q, rv_d;
	logic [8:0]        page_q, page_d;
	logic [8:0]        grant_q, grant_d;
	pfba_pkg::status_t status_q, status_d;
	logic              out_valid_q;
	logic [8:0]        alloc_page_q;
	pfba_pkg::status_t status_out_q;
	logic [9:0]        free_out_q;
	logic              out_load;

	logic [31:0]       mem [WORDS];
	logic [31:0]       rdata_q;
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [31:0]       wr_data;

	logic [BW-1:0]     limit_b, res_b, nwords_b;
	logic [9:0]        init_free;
	logic [31:0]       free_bits, low1;
	logic [4:0]        low_idx;
	logic              scan_hit;
	logic              last_word;

	always_comb begin
		limit_b = (BW'(total_q) > BW'(MAX_PAGES)) ? BW'(MAX_PAGES) : BW'(total_q);
		res_b = (BW'(reserved_q) > BW'(MAX_PAGES)) ? BW'(MAX_PAGES) : BW'(reserved_q);
		nwords_b = (limit_b + BW'(31)) >> 5;
		init_free = (res_b >= limit_b) ? 10'd0 : 10'(limit_b - res_b);
		last_word = (scan_w_q == CW'(WORDS - 1));
	end

	// Lowest free page inside the word under evaluation.
	always_comb begin
		free_bits = ~rdata_q & low_mask(BW'({ev_w_q, 5'b0}), limit_b);
		low1 = free_bits & (~free_bits + 32'd1);
		low_idx = '0;
		for (int i = 0; i < 32; i++) begin
			low_idx = low_idx | (low1[i] ? 5'(i) : 5'd0);
		end
	end

	assign scan_hit = (state_q == pfba_pkg::S_SCAN) && rv_q && (free_bits != 32'd0);

	always_comb begin
		state_d  = state_q;
		free_d   = free_q;
		scan_w_d = scan_w_q;
		ev_w_d   = ev_w_q;
		rv_d     = 1'b0;
		page_d   = page_q;
		grant_d  = grant_q;
		status_d = status_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			pfba_pkg::S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = scan_w_q[AW-1:0];
				if (last_word) begin
					scan_w_d = '0;
					state_d  = pfba_pkg::S_IDLE;
				end else begin
					scan_w_d = scan_w_q + CW'(1);
				end
			end
			pfba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					grant_d  = '0;
					status_d = pfba_pkg::ST_OK;
					scan_w_d = '0;
					page_d   = page;
					unique case (pfba_pkg::op_e_t'(op))
						pfba_pkg::OP_INIT: state_d = pfba_pkg::S_INIT;
						pfba_pkg::OP_ALLOC: begin
							if (free_q == 10'd0) begin
								status_d = pfba_pkg::ST_NOMEM;
								state_d  = pfba_pkg::S_RESP;
							end else begin
								state_d = pfba_pkg::S_SCAN;
							end
						end
						pfba_pkg::OP_FREE: begin
							if (BW'(page) >= limit_b) begin
								status_d = pfba_pkg::ST_BADPAGE;
								state_d  = pfba_pkg::S_RESP;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(page[8:5]);
								state_d = pfba_pkg::S_FREE_CHK;
							end
						end
						default: state_d = pfba_pkg::S_RESP;
					endcase
				end
			end
			pfba_pkg::S_INIT: begin
				wr_en   = 1'b1;
				wr_addr = scan_w_q[AW-1:0];
				wr_data = low_mask(BW'({scan_w_q, 5'b0}), res_b);
				if (last_word) begin
					free_d  = init_free;
					state_d = pfba_pkg::S_RESP;
				end else begin
					scan_w_d = scan_w_q + CW'(1);
				end
			end
			pfba_pkg::S_SCAN: begin
				// issue the next word read while the previous one is evaluated
				if (BW'(scan_w_q) < nwords_b) begin
					rd_en    = 1'b1;
					rd_addr  = scan_w_q[AW-1:0];
					ev_w_d   = scan_w_q[AW-1:0];
					rv_d     = 1'b1;
					scan_w_d = scan_w_q + CW'(1);
				end
				if (scan_hit) begin
					wr_en    = 1'b1;
					wr_addr  = ev_w_q;
					wr_data  = rdata_q | low1;
					grant_d  = 9'({ev_w_q, low_idx});
					free_d   = free_q - 10'd1;
					status_d = pfba_pkg::ST_OK;
					state_d  = pfba_pkg::S_RESP;
				end else if (!rv_q && !(BW'(scan_w_q) < nwords_b)) begin
					status_d = pfba_pkg::ST_NOMEM;
					state_d  = pfba_pkg::S_RESP;
				end
			end
			pfba_pkg::S_FREE_CHK: begin
				if (rdata_q[page_q[4:0]]) begin
					wr_en   = 1'b1;
					wr_addr = AW'(page_q[8:5]);
					wr_data = rdata_q & ~(32'd1 << page_q[4:0]);
					free_d  = (free_q == pfba_pkg::COUNT_MAX) ? free_q : free_q + 10'd1;
				end else begin
					status_d = pfba_pkg::ST_BADPAGE;
				end
				state_d = pfba_pkg::S_RESP;
			end
			pfba_pkg::S_RESP: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = pfba_pkg::S_IDLE;
				end
			end
			default: state_d = pfba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfba_pkg::S_CLEAR;
			scan_w_q    <= '0;
			rv_q        <= 1'b0;
			free_q      <= '0;
			total_q     <= pfba_pkg::TOTAL_RST;
			reserved_q  <= pfba_pkg::RESERVED_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			scan_w_q <= scan_w_d;
			rv_q     <= rv_d;
			free_q   <= free_d;
			if (cfg_we) begin
				unique case (pfba_pkg::reg_idx_t'(cfg_index))
					pfba_pkg::REG_TOTAL:    total_q    <= cfg_wdata;
					pfba_pkg::REG_RESERVED: reserved_q <= cfg_wdata;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ev_w_q   <= ev_w_d;
		page_q   <= page_d;
		grant_q  <= grant_d;
		status_q <= status_d;
		if (out_load) begin
			alloc_page_q <= grant_q;
			status_out_q <= status_q;
			free_out_q   <= free_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign out_valid  = out_valid_q;
	assign alloc_page = alloc_page_q;
	assign status     = status_out_q;
	assign free_count = free_out_q;

	`PFBA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken while busy")
	`PFBA_ASSERT_NOW(a_no_grant_on_error, out_valid && (status != pfba_pkg::ST_OK), alloc_page == 9'd0, "page granted on error")
	`PFBA_ASSERT_NOW(a_write_states, wr_en, (state_q == pfba_pkg::S_CLEAR) || (state_q == pfba_pkg::S_INIT) || (state_q == pfba_pkg::S_SCAN) || (state_q == pfba_pkg::S_FREE_CHK), "bitmap written outside a write state")
	`PFBA_ASSERT_NEXT(a_alloc_decrement, scan_hit, free_q == $past(free_q) - 10'd1, "free count not decremented on grant")

endmodule
